// ===== hdl/rqs_pkg.sv =====
// Shared types and constants for the record quicksort engine.
`timescale 1ns / 1ps
`default_nettype none
package rqs_pkg;
  localparam int DEF_CAPACITY = 32;
  localparam int KEY_W   = 64;
  localparam int YEAR_W  = 16;
  localparam int COLOR_W = 8;
  localparam int REC_W   = KEY_W + YEAR_W + COLOR_W;

  // record memory read address select
  localparam logic [2:0] RD_J     = 3'd0;
  localparam logic [2:0] RD_JM1   = 3'd1;
  localparam logic [2:0] RD_I     = 3'd2;
  localparam logic [2:0] RD_IP1   = 3'd3;
  localparam logic [2:0] RD_POPLO = 3'd4;
  localparam logic [2:0] RD_K     = 3'd5;

  typedef struct packed {
    logic       load;
    logic       sort_init;
    logic       pop;
    logic       pop_ld;
    logic       piv_ld;
    logic       j_dec;
    logic       hold_j;
    logic       i_inc;
    logic       hold_i;
    logic       sw1;
    logic       sw2;
    logic       push_r;
    logic       push_l;
    logic       out_ld;
    logic       out_adv;
    logic       clear;
    logic [2:0] rd_sel;
  } rqs_cmd_t;

  typedef struct packed {
    logic lt2;
    logic sp_zero;
    logic i_le_j;
    logic j_go;
    logic i_go;
    logic n_zero;
    logic out_last;
  } rqs_stat_t;
endpackage
`default_nettype wire

// ===== hdl/rqs_datapath.sv =====
// Record and range-stack storage, partition registers and output registers.
`timescale 1ns / 1ps
`default_nettype none
module rqs_datapath #(
  parameter int CAPACITY = rqs_pkg::DEF_CAPACITY
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  rqs_pkg::rqs_cmd_t            cmd,
  output rqs_pkg::rqs_stat_t           stat,
  input  wire [rqs_pkg::KEY_W-1:0]     in_plate_key,
  input  wire [rqs_pkg::YEAR_W-1:0]    in_year,
  input  wire [rqs_pkg::COLOR_W-1:0]   in_color,
  output logic [rqs_pkg::KEY_W-1:0]    out_sorted_key,
  output logic [rqs_pkg::YEAR_W-1:0]   out_sorted_year,
  output logic [rqs_pkg::COLOR_W-1:0]  out_sorted_color,
  output logic                         out_last_result,
  output logic                         out_dropped
);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = IDX_W + 2;
  localparam int SD    = CAPACITY + 2;
  localparam int SA_W  = $clog2(SD);
  localparam int SP_W  = $clog2(SD + 1);
  localparam int REC_W = rqs_pkg::REC_W;
  localparam int KEY_W = rqs_pkg::KEY_W;

  logic [REC_W-1:0]     mem_r [CAPACITY];
  logic [2*IDX_W-1:0]   stk_r [SD];
  logic [REC_W-1:0]     rdata_r;
  logic [2*IDX_W-1:0]   stk_rdata_r;
  logic [CNT_W-1:0]     count_r;
  logic                 ovf_r;
  logic [SP_W-1:0]      sp_r;
  logic [IDX_W-1:0]     lo_r, hi_r, k_r;
  logic signed [PW-1:0] i_r, j_r;
  logic [KEY_W-1:0]     pivot_r;
  logic [REC_W-1:0]     reci_r, recj_r;

  logic [IDX_W-1:0]     rd_addr;
  logic [SA_W-1:0]      stk_rd_addr;
  logic signed [PW-1:0] lo_s, hi_s;
  logic [KEY_W-1:0]     rd_key;
  logic [IDX_W-1:0]     n_m1;
  logic                 push_r_ok, push_l_ok;

  assign lo_s   = $signed({2'b00, lo_r});
  assign hi_s   = $signed({2'b00, hi_r});
  assign rd_key = rdata_r[REC_W-1 -: KEY_W];
  assign n_m1   = IDX_W'(count_r - CNT_W'(1));
  assign push_r_ok = (i_r < hi_s) && (sp_r < SP_W'(SD));
  assign push_l_ok = (j_r > lo_s) && (sp_r < SP_W'(SD));
  assign stk_rd_addr = SA_W'(sp_r - SP_W'(1));

  // Select the record memory read address
  always_comb begin
    unique case (cmd.rd_sel)
      rqs_pkg::RD_J:     rd_addr = j_r[IDX_W-1:0];
      rqs_pkg::RD_JM1:   rd_addr = IDX_W'(j_r - PW'(1));
      rqs_pkg::RD_I:     rd_addr = i_r[IDX_W-1:0];
      rqs_pkg::RD_IP1:   rd_addr = IDX_W'(i_r + PW'(1));
      rqs_pkg::RD_POPLO: rd_addr = stk_rdata_r[2*IDX_W-1 -: IDX_W];
      default:           rd_addr = k_r;
    endcase
  end

  // Report status to the controller
  always_comb begin
    stat.lt2      = (count_r < CNT_W'(2));
    stat.sp_zero  = (sp_r == '0);
    stat.i_le_j   = (i_r <= j_r);
    stat.j_go     = (j_r > lo_s) && (rd_key > pivot_r);
    stat.i_go     = (i_r < hi_s) && (rd_key < pivot_r);
    stat.n_zero   = (count_r == '0);
    stat.out_last = (k_r == n_m1);
  end

  // Record memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load && (count_r < CNT_W'(CAPACITY))) begin
      mem_r[count_r[IDX_W-1:0]] <= {in_plate_key, in_year, in_color};
    end else if (cmd.sw1) begin
      mem_r[i_r[IDX_W-1:0]] <= recj_r;
    end else if (cmd.sw2) begin
      mem_r[j_r[IDX_W-1:0]] <= reci_r;
    end
    rdata_r <= mem_r[rd_addr];
  end

  // Range stack memory
  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      stk_r[0] <= {{IDX_W{1'b0}}, n_m1};
    end else if (cmd.push_r && push_r_ok) begin
      stk_r[sp_r[SA_W-1:0]] <= {i_r[IDX_W-1:0], hi_r};
    end else if (cmd.push_l && push_l_ok) begin
      stk_r[sp_r[SA_W-1:0]] <= {lo_r, j_r[IDX_W-1:0]};
    end
    stk_rdata_r <= stk_r[stk_rd_addr];
  end

  // Control registers: fill count, overflow flag, stack pointer, output index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      sp_r    <= '0;
      k_r     <= '0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        k_r     <= '0;
      end else if (cmd.load) begin
        if (count_r < CNT_W'(CAPACITY)) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end else if (cmd.out_adv) begin
        k_r <= k_r + IDX_W'(1);
      end
      if (cmd.sort_init) begin
        sp_r <= SP_W'(1);
      end else if (cmd.pop) begin
        sp_r <= sp_r - SP_W'(1);
      end else if ((cmd.push_r && push_r_ok) || (cmd.push_l && push_l_ok)) begin
        sp_r <= sp_r + SP_W'(1);
      end
    end
  end

  // Partition registers
  always_ff @(posedge clk) begin
    if (cmd.pop_ld) begin
      lo_r <= stk_rdata_r[2*IDX_W-1 -: IDX_W];
      hi_r <= stk_rdata_r[IDX_W-1:0];
      i_r  <= $signed({2'b00, stk_rdata_r[2*IDX_W-1 -: IDX_W]});
      j_r  <= $signed({2'b00, stk_rdata_r[IDX_W-1:0]});
    end else begin
      if (cmd.j_dec || cmd.sw2) begin
        j_r <= j_r - PW'(1);
      end
      if (cmd.i_inc || cmd.sw2) begin
        i_r <= i_r + PW'(1);
      end
    end
    if (cmd.piv_ld) begin
      pivot_r <= rd_key;
    end
    if (cmd.hold_j) begin
      recj_r <= rdata_r;
    end
    if (cmd.hold_i) begin
      reci_r <= rdata_r;
    end
  end

  // Output registers
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      {out_sorted_key, out_sorted_year, out_sorted_color} <= rdata_r;
      out_last_result <= (k_r == n_m1);
      out_dropped     <= ovf_r;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/rqs_ctrl.sv =====
// Sequencer for loading, partitioning, range stack handling and unloading.
`timescale 1ns / 1ps
`default_nettype none
module rqs_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                in_last_item,
  output logic               out_valid,
  input  wire                out_ready,
  input  rqs_pkg::rqs_stat_t stat,
  output rqs_pkg::rqs_cmd_t  cmd
);
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_SINIT = 4'd1;
  localparam logic [3:0] S_POP   = 4'd2;
  localparam logic [3:0] S_POPLD = 4'd3;
  localparam logic [3:0] S_PIV   = 4'd4;
  localparam logic [3:0] S_LOOP  = 4'd5;
  localparam logic [3:0] S_JCHK  = 4'd6;
  localparam logic [3:0] S_ICHK  = 4'd7;
  localparam logic [3:0] S_SW1   = 4'd8;
  localparam logic [3:0] S_SW2   = 4'd9;
  localparam logic [3:0] S_PUSHR = 4'd10;
  localparam logic [3:0] S_PUSHL = 4'd11;
  localparam logic [3:0] S_OUTRD = 4'd12;
  localparam logic [3:0] S_OUTLD = 4'd13;
  localparam logic [3:0] S_OUTWT = 4'd14;

  logic [3:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_LOAD);
  assign out_valid = (state_r == S_OUTWT);

  // Decode state into datapath commands
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = rqs_pkg::RD_K;
    state_nxt  = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last_item) state_nxt = S_SINIT;
        end
      end
      S_SINIT: begin
        if (stat.lt2) begin
          state_nxt = S_OUTRD;
        end else begin
          cmd.sort_init = 1'b1;
          state_nxt     = S_POP;
        end
      end
      S_POP: begin
        if (stat.sp_zero) begin
          state_nxt = S_OUTRD;
        end else begin
          cmd.pop   = 1'b1;
          state_nxt = S_POPLD;
        end
      end
      S_POPLD: begin
        cmd.pop_ld = 1'b1;
        cmd.rd_sel = rqs_pkg::RD_POPLO;
        state_nxt  = S_PIV;
      end
      S_PIV: begin
        cmd.piv_ld = 1'b1;
        state_nxt  = S_LOOP;
      end
      S_LOOP: begin
        cmd.rd_sel = rqs_pkg::RD_J;
        state_nxt  = stat.i_le_j ? S_JCHK : S_PUSHR;
      end
      // scan j down past keys above the pivot
      S_JCHK: begin
        if (stat.j_go) begin
          cmd.j_dec  = 1'b1;
          cmd.rd_sel = rqs_pkg::RD_JM1;
        end else begin
          cmd.hold_j = 1'b1;
          cmd.rd_sel = rqs_pkg::RD_I;
          state_nxt  = S_ICHK;
        end
      end
      // scan i up past keys below the pivot
      S_ICHK: begin
        if (stat.i_go) begin
          cmd.i_inc  = 1'b1;
          cmd.rd_sel = rqs_pkg::RD_IP1;
        end else begin
          cmd.hold_i = 1'b1;
          state_nxt  = stat.i_le_j ? S_SW1 : S_PUSHR;
        end
      end
      S_SW1: begin
        cmd.sw1   = 1'b1;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        cmd.sw2   = 1'b1;
        state_nxt = S_LOOP;
      end
      S_PUSHR: begin
        cmd.push_r = 1'b1;
        state_nxt  = S_PUSHL;
      end
      S_PUSHL: begin
        cmd.push_l = 1'b1;
        state_nxt  = S_POP;
      end
      S_OUTRD: begin
        if (stat.n_zero) begin
          cmd.clear = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_OUTLD;
        end
      end
      S_OUTLD: begin
        cmd.out_ld = 1'b1;
        state_nxt  = S_OUTWT;
      end
      S_OUTWT: begin
        if (out_ready) begin
          if (stat.out_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            cmd.out_adv = 1'b1;
            state_nxt   = S_OUTRD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/record_quicksort_engine_top.sv =====
// Record sorter: top level joining the sequencer and the datapath.
// Loading accepts one record request per cycle. After the last request the set is
// sorted in place through one record memory: one key compare per scan step, a swap
// writes the two records in turn, and each popped range loads its bounds and pivot.
// Unloading reads, registers and offers one result at a time, holding it until the output side is ready.
// Synchronous reset empties the store and clears the overflow flag; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module record_quicksort_engine_top #(
  parameter int CAPACITY = rqs_pkg::DEF_CAPACITY
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [rqs_pkg::KEY_W-1:0]     in_plate_key,
  input  wire [rqs_pkg::YEAR_W-1:0]    in_year,
  input  wire [rqs_pkg::COLOR_W-1:0]   in_color,
  input  wire                          in_last_item,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [rqs_pkg::KEY_W-1:0]    out_sorted_key,
  output logic [rqs_pkg::YEAR_W-1:0]   out_sorted_year,
  output logic [rqs_pkg::COLOR_W-1:0]  out_sorted_color,
  output logic                         out_last_result,
  output logic                         out_dropped
);
  rqs_pkg::rqs_cmd_t  cmd;
  rqs_pkg::rqs_stat_t stat;

  // Sequencer
  rqs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_last_item (in_last_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Storage and compare logic
  rqs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_plate_key     (in_plate_key),
    .in_year          (in_year),
    .in_color         (in_color),
    .out_sorted_key   (out_sorted_key),
    .out_sorted_year  (out_sorted_year),
    .out_sorted_color (out_sorted_color),
    .out_last_result  (out_last_result),
    .out_dropped      (out_dropped)
  );
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the record quicksort engine: load, sort and unload.
`timescale 1ns / 1ps
module tb_top;
  localparam int CAP      = rqs_pkg::DEF_CAPACITY;
  localparam int KEY_W    = rqs_pkg::KEY_W;
  localparam int YEAR_W   = rqs_pkg::YEAR_W;
  localparam int COLOR_W  = rqs_pkg::COLOR_W;
  localparam int WDOG_MAX = 40000;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [YEAR_W-1:0]  year;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               dropped;
  } sorted_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KEY_W-1:0] in_plate_key = '0;
  logic [YEAR_W-1:0] in_year = '0;
  logic [COLOR_W-1:0] in_color = '0;
  logic in_last_item = 1'b0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [KEY_W-1:0] out_sorted_key;
  logic [YEAR_W-1:0] out_sorted_year;
  logic [COLOR_W-1:0] out_sorted_color;
  logic out_last_result;
  logic out_dropped;

  // record set held by the predictor
  logic [KEY_W-1:0]   pkey [CAP];
  logic [YEAR_W-1:0]  pyear[CAP];
  logic [COLOR_W-1:0] pcolor[CAP];
  int pcount = 0;
  bit povf = 0;

  sorted_rec_t sorted_q[$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatches = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int sets_sorted = 0;
  int sets_dropped = 0;
  int idle_cycles = 0;

  record_quicksort_engine_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_plate_key(in_plate_key), .in_year(in_year), .in_color(in_color),
    .in_last_item(in_last_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_sorted_key(out_sorted_key), .out_sorted_year(out_sorted_year),
    .out_sorted_color(out_sorted_color), .out_last_result(out_last_result),
    .out_dropped(out_dropped)
  );

  always #5 clk = ~clk;

  // swap two held records
  task automatic swap_recs(input int a, input int b);
    logic [KEY_W-1:0] k;
    logic [YEAR_W-1:0] y;
    logic [COLOR_W-1:0] c;
    k = pkey[a]; y = pyear[a]; c = pcolor[a];
    pkey[a] = pkey[b]; pyear[a] = pyear[b]; pcolor[a] = pcolor[b];
    pkey[b] = k; pyear[b] = y; pcolor[b] = c;
  endtask

  // Hoare partition quicksort, first element as pivot, explicit range stack
  task automatic hoare_sort(input int n);
    int stk_lo[CAP+2];
    int stk_hi[CAP+2];
    int sp, lo, hi, i, j;
    logic [KEY_W-1:0] pivot;
    if (n < 2) return;
    stk_lo[0] = 0; stk_hi[0] = n - 1; sp = 1;
    while (sp > 0) begin
      sp--;
      lo = stk_lo[sp]; hi = stk_hi[sp];
      pivot = pkey[lo];
      i = lo; j = hi;
      while (i <= j) begin
        while (j > lo && pkey[j] > pivot) j--;
        while (i < hi && pkey[i] < pivot) i++;
        if (i <= j) begin
          swap_recs(i, j);
          j--; i++;
        end
      end
      if (i < hi && sp < CAP + 2) begin
        stk_lo[sp] = i; stk_hi[sp] = hi; sp++;
      end
      if (j > lo && sp < CAP + 2) begin
        stk_lo[sp] = lo; stk_hi[sp] = j; sp++;
      end
    end
  endtask

  // store one accepted request; on the last mark queue the sorted set
  task automatic predict_request(input logic [KEY_W-1:0] k, input logic [YEAR_W-1:0] y,
                                 input logic [COLOR_W-1:0] c, input logic lst);
    sorted_rec_t r;
    if (pcount < CAP) begin
      pkey[pcount] = k; pyear[pcount] = y; pcolor[pcount] = c;
      pcount++;
    end else begin
      povf = 1;
    end
    if (!lst) return;
    hoare_sort(pcount);
    for (int m = 0; m < pcount; m++) begin
      r.key = pkey[m]; r.year = pyear[m]; r.color = pcolor[m];
      r.last = (m == pcount - 1); r.dropped = povf;
      sorted_q.push_back(r);
    end
    sets_sorted++;
    if (povf) sets_dropped++;
    pcount = 0;
    povf = 0;
  endtask

  // send one request, with a random gap in front of it
  task automatic send_request(input logic [KEY_W-1:0] k, input logic [YEAR_W-1:0] y,
                              input logic [COLOR_W-1:0] c, input logic lst);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_plate_key <= k; in_year <= y; in_color <= c; in_last_item <= lst;
    do @(posedge clk); while (!in_ready);
    predict_request(k, y, c, lst);
    requests_sent++;
  endtask

  // hold off until every queued result has been unloaded
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_key(input int mode);
    case (mode)
      0: rand_key = {$urandom, $urandom};
      1: rand_key = {56'(0), 8'($urandom_range(3))} << (8 * $urandom_range(7));
      default: rand_key = {8'h41 + 8'($urandom_range(25)), 8'h41 + 8'($urandom_range(3)),
                           8'h30 + 8'($urandom_range(9)), 40'h0};
    endcase
  endfunction

  // send one whole set of random records
  task automatic send_set(input int n, input int mode);
    for (int m = 0; m < n; m++)
      send_request(rand_key(mode), 16'($urandom), 8'($urandom), m == n - 1);
  endtask

  task automatic test_single_record();
    send_request(64'h4142_4331_3233_0000, 16'd2001, 8'd7, 1'b1);
  endtask

  // all-zero, all-one and single-bit fields, then a set sent in sorted order
  task automatic test_field_extremes();
    send_request('1, '1, '1, 1'b0);
    send_request('0, '0, '0, 1'b0);
    send_request(64'h8000_0000_0000_0000, 16'h8000, 8'h80, 1'b0);
    send_request(64'h0000_0000_0000_0001, 16'h0001, 8'h01, 1'b1);
    for (int m = 0; m < 5; m++)
      send_request(64'(m) << 56, 16'(m), 8'(m), m == 4);
  endtask

  // equal keys: order follows the partition exactly
  task automatic test_equal_keys();
    for (int m = 0; m < 6; m++)
      send_request((m % 2) ? 64'h5A : 64'h3C, 16'(100 + m), 8'(m), m == 5);
  endtask

  // store full: extra records drop, also when the dropped one carries the last mark
  task automatic test_store_full();
    send_set(CAP + 2, 0);
    wait_drained();
    send_set(CAP, 1);
    wait_drained();
    send_set(CAP + 1, 2);
  endtask

  task automatic test_random_sets(input int budget, input int tx_pct, input int rx_pct);
    int sent0;
    int n;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent0 = requests_sent;
    while (requests_sent - sent0 < budget) begin
      if ($urandom_range(9) == 0) n = $urandom_range(CAP - 2, CAP + 3);
      else n = $urandom_range(1, 12);
      send_set(n, $urandom_range(2));
    end
    wait_drained();
  endtask

  // receiver stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // compare each unloaded result with the oldest expectation
  always @(posedge clk) begin
    sorted_rec_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result key=%h year=%h color=%h",
                   out_sorted_key, out_sorted_year, out_sorted_color);
      end else begin
        e = sorted_q.pop_front();
        if (e.key !== out_sorted_key || e.year !== out_sorted_year ||
            e.color !== out_sorted_color || e.last !== out_last_result ||
            e.dropped !== out_dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp key=%h yr=%h col=%h last=%b drop=%b, got %h %h %h %b %b",
                     e.key, e.year, e.color, e.last, e.dropped, out_sorted_key,
                     out_sorted_year, out_sorted_color, out_last_result, out_dropped);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("record_quicksort_engine_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_record();
    test_field_extremes();
    test_equal_keys();
    wait_drained();
    test_store_full();
    wait_drained();
    test_random_sets(120, 12, 82);
    test_random_sets(120, 82, 12);
    test_random_sets(100, 0, 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d requests in %0d sets (%0d with dropped records), %0d results.",
             requests_sent, sets_sorted, sets_dropped, results_seen);
    if (mismatches == 0 && sorted_q.size() == 0)
      $display("record_quicksort_engine_top test passed");
    else
      $display("record_quicksort_engine_top test failed");
    $finish;
  end
endmodule
